>>> sv/rfgc_pkg.sv
package rfgc_pkg;

  // Table geometry
  localparam int unsigned GROUP_CAPACITY = 64;
  localparam int unsigned KEY_BYTES      = 5;
  localparam int unsigned IDX_W          = $clog2(GROUP_CAPACITY);
  localparam int unsigned FILL_W         = $clog2(GROUP_CAPACITY + 1);

  // Field widths
  localparam int unsigned KEY_W   = 40;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GRP_W   = 7;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 112;

  localparam int unsigned KEY_BITS = KEY_BYTES * 8;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Command codes and register indexes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FL_READ,
    ST_FL_LOAD,
    ST_FL_EMPTY
  } rfgc_state_e;

  // Table port requests
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } tbl_wr_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

>>> sv/rfgc_table.sv
module rfgc_table (
  input  logic                     clk_i,
  input  rfgc_pkg::tbl_rd_t        rd_i,
  input  rfgc_pkg::tbl_wr_t        wr_i,
  output logic [rfgc_pkg::KEY_W-1:0] rd_key_o,
  output logic [rfgc_pkg::CNT_W-1:0] rd_cnt_o
);

  logic [rfgc_pkg::KEY_W-1:0] key_mem [rfgc_pkg::GROUP_CAPACITY];
  logic [rfgc_pkg::CNT_W-1:0] cnt_mem [rfgc_pkg::GROUP_CAPACITY];
  logic [rfgc_pkg::KEY_W-1:0] rd_key_q;
  logic [rfgc_pkg::CNT_W-1:0] rd_cnt_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_mem[wr_i.addr] <= wr_i.key;
      cnt_mem[wr_i.addr] <= wr_i.cnt;
    end
  end

  // Read one entry, hold data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_key_q <= key_mem[rd_i.addr];
      rd_cnt_q <= cnt_mem[rd_i.addr];
    end
  end

  assign rd_key_o = rd_key_q;
  assign rd_cnt_o = rd_cnt_q;

endmodule

>>> sv/range_filter_group_count.sv
// Range filter followed by a group-by count.
// Input stream: tuser is the command (record or flush); tdata carries the
// filter byte and the 40-bit group key. Every record bumps a saturating
// record total; a record whose filter byte lies in [range_low, range_high]
// is looked up in a 64-entry group table by one comparator that walks the
// table one entry per cycle behind a registered read port.
// A selected record keeps ready low while it walks the table; a filtered-out
// record leaves ready high.
// A flush emits one word per group in first-seen order (or one word with
// tuser low when the table is empty), each read and then registered, pausing
// on output stalls, then clears the table, record total and overflow flag.
// Output words sit in a register: a stalled receiver holds the current word
// and the flush pauses; records may still be accepted while the last word of
// a flush waits.
// Config channel: index 0 = range_low, 1 = range_high; always ready. The user
// must write it while the block is idle; the block itself does not enforce this.
// Reset empties the table and restores range_low 0, range_high 255.
module range_filter_group_count (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [rfgc_pkg::IN_W-1:0]   s_axis_tdata,  // filter_byte, group_key
  input  logic                        s_axis_tuser,  // command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_key, out_count, records_seen, groups_found, table_overflow
  output logic [rfgc_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                        m_axis_tuser,  // group_valid
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_addr_i,
  input  logic [rfgc_pkg::BYTE_W-1:0] cfg_data_i
);

  rfgc_pkg::rfgc_state_e state_q, state_d;

  logic [rfgc_pkg::BYTE_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [rfgc_pkg::KEY_W-1:0]  key_q, key_d;
  logic [rfgc_pkg::FILL_W-1:0] ptr_q, ptr_d, fill_q, fill_d;
  logic [rfgc_pkg::IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic                        pend_q, pend_d;
  logic [rfgc_pkg::CNT_W-1:0]  total_q, total_d;
  logic                        ovf_q, ovf_d;

  logic                        ov_valid_q, ov_valid_d;
  logic [rfgc_pkg::OUT_W-1:0]  ov_data_q, ov_data_d;
  logic                        ov_user_q, ov_user_d;
  logic                        ov_last_q, ov_last_d;

  rfgc_pkg::tbl_rd_t           tbl_rd;
  rfgc_pkg::tbl_wr_t           tbl_wr;
  logic [rfgc_pkg::KEY_W-1:0]  tbl_key;
  logic [rfgc_pkg::CNT_W-1:0]  tbl_cnt;

  logic in_acc, is_flush, in_range, issue, hit, exhausted, slot_free, has_room, fl_last;
  logic [rfgc_pkg::BYTE_W-1:0] in_byte;

  rfgc_table u_table (
    .clk_i    (clk_i),
    .rd_i     (tbl_rd),
    .wr_i     (tbl_wr),
    .rd_key_o (tbl_key),
    .rd_cnt_o (tbl_cnt)
  );

  // Handshake and search status
  always_comb begin
    in_acc    = s_axis_tvalid && s_axis_tready;
    is_flush  = (s_axis_tuser == rfgc_pkg::CMD_FLUSH);
    in_byte   = s_axis_tdata[rfgc_pkg::BYTE_W-1:0];
    in_range  = (in_byte >= lo_q) && (in_byte <= hi_q);
    issue     = (state_q == rfgc_pkg::ST_SEARCH) && (ptr_q < fill_q);
    hit       = (state_q == rfgc_pkg::ST_SEARCH) && pend_q && (tbl_key == key_q);
    exhausted = (state_q == rfgc_pkg::ST_SEARCH) && !pend_q && (ptr_q == fill_q);
    slot_free = !ov_valid_q || m_axis_tready;
    has_room  = fill_q < rfgc_pkg::FILL_W'(rfgc_pkg::GROUP_CAPACITY);
    fl_last   = (ptr_q + rfgc_pkg::FILL_W'(1)) == fill_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfgc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_flush) begin
            state_d = (fill_q == '0) ? rfgc_pkg::ST_FL_EMPTY : rfgc_pkg::ST_FL_READ;
          end else if (in_range) begin
            state_d = rfgc_pkg::ST_SEARCH;
          end
        end
      end
      rfgc_pkg::ST_SEARCH: begin
        if (hit || exhausted) state_d = rfgc_pkg::ST_IDLE;
      end
      rfgc_pkg::ST_FL_READ: state_d = rfgc_pkg::ST_FL_LOAD;
      rfgc_pkg::ST_FL_LOAD: begin
        if (slot_free) state_d = fl_last ? rfgc_pkg::ST_IDLE : rfgc_pkg::ST_FL_READ;
      end
      rfgc_pkg::ST_FL_EMPTY: begin
        if (slot_free) state_d = rfgc_pkg::ST_IDLE;
      end
      default: state_d = rfgc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    lo_d       = lo_q;
    hi_d       = hi_q;
    key_d      = key_q;
    ptr_d      = ptr_q;
    fill_d     = fill_q;
    cmp_idx_d  = cmp_idx_q;
    pend_d     = 1'b0;
    total_d    = total_q;
    ovf_d      = ovf_q;
    ov_valid_d = ov_valid_q && !m_axis_tready;
    ov_data_d  = ov_data_q;
    ov_user_d  = ov_user_q;
    ov_last_d  = ov_last_q;
    tbl_rd     = '{en: 1'b0, addr: ptr_q[rfgc_pkg::IDX_W-1:0]};
    tbl_wr     = '{en: 1'b0, addr: cmp_idx_q, key: key_q, cnt: rfgc_pkg::sat_inc(tbl_cnt)};

    // Take register writes
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        rfgc_pkg::REG_RANGE_LOW:  lo_d = cfg_data_i;
        rfgc_pkg::REG_RANGE_HIGH: hi_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      rfgc_pkg::ST_IDLE: begin
        ptr_d = '0;
        if (in_acc && !is_flush) begin
          total_d = rfgc_pkg::sat_inc(total_q);
          key_d   = s_axis_tdata[rfgc_pkg::IN_W-1:rfgc_pkg::BYTE_W] & rfgc_pkg::KEY_MASK;
        end
      end
      rfgc_pkg::ST_SEARCH: begin
        // Issue the next read, compare the one read last cycle
        if (issue && !hit) begin
          tbl_rd.en = 1'b1;
          ptr_d     = ptr_q + rfgc_pkg::FILL_W'(1);
          cmp_idx_d = ptr_q[rfgc_pkg::IDX_W-1:0];
          pend_d    = 1'b1;
        end
        if (hit) begin
          tbl_wr.en = 1'b1;
        end else if (exhausted) begin
          if (has_room) begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = fill_q[rfgc_pkg::IDX_W-1:0];
            tbl_wr.cnt  = rfgc_pkg::CNT_W'(1);
            fill_d      = fill_q + rfgc_pkg::FILL_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      rfgc_pkg::ST_FL_READ: begin
        tbl_rd.en = 1'b1;
      end
      rfgc_pkg::ST_FL_LOAD: begin
        if (slot_free) begin
          ov_valid_d = 1'b1;
          ov_data_d  = {ovf_q, fill_q, total_q, tbl_cnt, tbl_key};
          ov_user_d  = 1'b1;
          ov_last_d  = fl_last;
          ptr_d      = ptr_q + rfgc_pkg::FILL_W'(1);
          if (fl_last) begin
            fill_d  = '0;
            total_d = '0;
            ovf_d   = 1'b0;
            ptr_d   = '0;
          end
        end
      end
      rfgc_pkg::ST_FL_EMPTY: begin
        if (slot_free) begin
          ov_valid_d = 1'b1;
          ov_data_d  = {ovf_q, fill_q, total_q, rfgc_pkg::CNT_W'(0), rfgc_pkg::KEY_W'(0)};
          ov_user_d  = 1'b0;
          ov_last_d  = 1'b1;
          total_d    = '0;
          ovf_d      = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rfgc_pkg::ST_IDLE;
      lo_q       <= '0;
      hi_q       <= '1;
      ptr_q      <= '0;
      fill_q     <= '0;
      cmp_idx_q  <= '0;
      pend_q     <= 1'b0;
      total_q    <= '0;
      ovf_q      <= 1'b0;
      ov_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      ptr_q      <= ptr_d;
      fill_q     <= fill_d;
      cmp_idx_q  <= cmp_idx_d;
      pend_q     <= pend_d;
      total_q    <= total_d;
      ovf_q      <= ovf_d;
      ov_valid_q <= ov_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    ov_data_q <= ov_data_d;
    ov_user_q <= ov_user_d;
    ov_last_q <= ov_last_d;
  end

  assign s_axis_tready = (state_q == rfgc_pkg::ST_IDLE);
  assign m_axis_tvalid = ov_valid_q;
  assign m_axis_tdata  = ov_data_q;
  assign m_axis_tuser  = ov_user_q;
  assign m_axis_tlast  = ov_last_q;
  assign cfg_ready_o   = 1'b1;

endmodule

>>> sv/rfgc_checker.sv
module rfgc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [rfgc_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                       m_axis_tuser,
  input logic                       m_axis_tlast
);

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // An empty-table word is the only and last word, with no groups
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tlast && (m_axis_tdata[110:104] == 7'd0) && (m_axis_tdata[71:0] == 72'd0))
    else $error("empty-table word malformed");

  // A group word reports a nonzero group count
  a_group_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[110:104] != 7'd0) && (m_axis_tdata[71:40] != 32'd0))
    else $error("group word without groups or count");

  // A flush keeps the input side busy
  a_flush_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input accepted right after flush");

endmodule

bind range_filter_group_count rfgc_checker u_rfgc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
